// ===== rtl/sdtq_pkg.sv =====
// shared types and codes for the sorted deadline timer queue
// used by sdtq_alloc and sorted_deadline_timer_queue_unit; no dependencies
`default_nettype none

package sdtq_pkg;

    // default number of timer slots
    localparam int TIMER_SLOTS_DEF = 16;

    // width of tick count, deadlines and user tags
    localparam int TW = 32;

    // operation codes carried in s_tuser
    localparam logic [1:0] MODE_CREATE = 2'd0;
    localparam logic [1:0] MODE_DELETE = 2'd1;
    localparam logic [1:0] MODE_TICK   = 2'd2;

    // status codes of a result beat
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_ZERO     = 2'd1;
    localparam logic [1:0] STAT_FULL     = 2'd2;
    localparam logic [1:0] STAT_INACTIVE = 2'd3;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_HEAD,
        S_WALK,
        S_RESP
    } state_t;

    // requests to the handle allocator
    typedef struct packed {
        logic scan_start;
        logic scan_step;
        logic set_en;
        logic clr_en;
    } alloc_ctrl_t;

    // allocator scan status
    typedef struct packed {
        logic found;
        logic exhausted;
    } alloc_stat_t;

endpackage

`default_nettype wire

// ===== rtl/sdtq_alloc.sv =====
// handle allocator: one in-use bit per handle and a lowest-free scan
// depends on sdtq_pkg
`default_nettype none

module sdtq_alloc #(
    parameter int TIMER_SLOTS = sdtq_pkg::TIMER_SLOTS_DEF
) (
    input  wire                             clk,
    input  wire                             rst_n,
    input  sdtq_pkg::alloc_ctrl_t           ctrl,
    input  wire [$clog2(TIMER_SLOTS)-1:0]   upd_handle,
    input  wire [$clog2(TIMER_SLOTS)-1:0]   chk_handle,
    output logic                            chk_active,
    output sdtq_pkg::alloc_stat_t           stat,
    output logic [$clog2(TIMER_SLOTS)-1:0]  free_handle
);
    import sdtq_pkg::*;

    localparam int HW = $clog2(TIMER_SLOTS);
    localparam logic [HW-1:0] LAST_H = HW'(TIMER_SLOTS - 1);

    logic [TIMER_SLOTS-1:0] in_use_reg;
    logic [TIMER_SLOTS-1:0] in_use_next;
    logic [HW-1:0]          scan_reg;
    logic [HW-1:0]          scan_next;
    logic                   scan_used;

    // active check for a delete request, out-of-range handles are inactive
    assign chk_active = (int'(chk_handle) < TIMER_SLOTS) && in_use_reg[chk_handle];

    // one handle examined per cycle
    assign scan_used      = in_use_reg[scan_reg];
    assign stat.found     = ctrl.scan_step && !scan_used;
    assign stat.exhausted = ctrl.scan_step && scan_used && (scan_reg == LAST_H);
    assign free_handle    = scan_reg;

    // scan pointer
    always_comb
    begin
        scan_next = scan_reg;
        if (ctrl.scan_start)
        begin
            scan_next = '0;
        end
        else if (ctrl.scan_step && scan_used && (scan_reg != LAST_H))
        begin
            scan_next = scan_reg + 1'b1;
        end
    end

    // in-use bits
    always_comb
    begin
        in_use_next = in_use_reg;
        if (ctrl.set_en)
        begin
            in_use_next[upd_handle] = 1'b1;
        end
        if (ctrl.clr_en)
        begin
            in_use_next[upd_handle] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_use_reg <= '0;
            scan_reg   <= '0;
        end
        else
        begin
            in_use_reg <= in_use_next;
            scan_reg   <= scan_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sorted_deadline_timer_queue_unit.sv =====
// sorted deadline timer queue: top level with list memory and walk sequencer
// depends on sdtq_pkg and sdtq_alloc
//
// Usage: one command beat enters on the s_ channel, mode in s_tuser (create,
// delete or tick); timeout, user tag and handle in s_tdata. Every command
// gives exactly one result beat on the m_ channel: status, new handle and,
// for a tick, the fired flag with the expired timer's handle and tag.
// The timers sit in one list memory sorted by deadline, read through a
// register; every create, delete or firing tick walks the valid entries
// once, reading entry i while the entry before it is written back shifted.
// A create first searches for h, the lowest free handle, one handle per
// cycle; a tick that does not fire, a tick on an empty list and a
// rejected command skip the walk.
// One command is worked on at a time; s_tready is high while the sequencer
// is idle, and the next command is taken while a result still waits in the
// output register. A stalled receiver holds the result register; a second
// result waits in the sequencer until that register frees up.
// Reset clears the tick count, the entry count and all handles; the list
// memory needs no clearing since only the first count entries are read.
`default_nettype none

module sorted_deadline_timer_queue_unit #(
    parameter int TIMER_SLOTS = sdtq_pkg::TIMER_SLOTS_DEF
) (
    input  wire                                                   clk,
    input  wire                                                   rst_n,
    // s_tdata: timeout[31:0], user_tag[63:32], handle above, zero pad
    input  wire                                                   s_tvalid,
    output logic                                                  s_tready,
    input  wire [((2*sdtq_pkg::TW+$clog2(TIMER_SLOTS)+7)/8)*8-1:0] s_tdata,
    // s_tuser: mode[1:0]
    input  wire [1:0]                                             s_tuser,
    // m_tdata: status[1:0], new_handle, fired, fired_handle, fired_tag, zero pad
    output logic                                                  m_tvalid,
    input  wire                                                   m_tready,
    output logic [((sdtq_pkg::TW+3+2*$clog2(TIMER_SLOTS)+7)/8)*8-1:0] m_tdata
);
    import sdtq_pkg::*;

    localparam int HW    = $clog2(TIMER_SLOTS);
    localparam int CW    = $clog2(TIMER_SLOTS + 1);
    localparam int ENT_W = 2 * TW + HW;
    localparam int OUT_F = TW + 3 + 2 * HW;
    localparam int OUT_W = ((OUT_F + 7) / 8) * 8;
    localparam logic [CW-1:0] SLOTS_C = CW'(TIMER_SLOTS);

    // list memory: {handle, tag, deadline} per entry
    logic [ENT_W-1:0] mem [TIMER_SLOTS];
    logic [ENT_W-1:0] rd_data_reg;
    logic             mem_we;
    logic [HW-1:0]    mem_waddr;
    logic [ENT_W-1:0] mem_wdata;
    logic             mem_re;
    logic [HW-1:0]    mem_raddr;

    state_t           state_reg, state_next;
    logic [TW-1:0]    tick_reg, tick_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [CW-1:0]    i_reg, i_next;
    logic             pend_reg, pend_next;
    logic [HW-1:0]    p_idx_reg, p_idx_next;
    logic             flag_reg, flag_next;
    logic             del_reg, del_next;
    logic [ENT_W-1:0] carry_reg, carry_next;
    logic [ENT_W-1:0] ent_reg, ent_next;
    logic [HW-1:0]    tgt_reg, tgt_next;

    // result fields
    logic [1:0]       status_reg, status_next;
    logic [HW-1:0]    nh_reg, nh_next;
    logic             fired_reg, fired_next;
    logic [HW-1:0]    fh_reg, fh_next;
    logic [TW-1:0]    ftag_reg, ftag_next;

    // output register
    logic             m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0] m_tdata_reg, m_tdata_next;

    // input fields
    logic [TW-1:0]    in_timeout;
    logic [TW-1:0]    in_tag;
    logic [HW-1:0]    in_handle;
    logic             accept;

    // read data fields
    logic [TW-1:0]    rd_dl;
    logic [TW-1:0]    rd_tag;
    logic [HW-1:0]    rd_hdl;

    logic             out_free;
    logic             walk_end;
    logic             create_go;
    logic             delete_go;

    // allocator link
    alloc_ctrl_t      actl;
    alloc_stat_t      astat;
    logic [HW-1:0]    upd_handle;
    logic             chk_active;
    logic [HW-1:0]    free_handle;

    assign in_timeout = s_tdata[TW-1:0];
    assign in_tag     = s_tdata[2*TW-1:TW];
    assign in_handle  = s_tdata[2*TW+HW-1:2*TW];
    assign s_tready   = (state_reg == S_IDLE);
    assign accept     = s_tvalid && s_tready;

    assign rd_dl  = rd_data_reg[TW-1:0];
    assign rd_tag = rd_data_reg[2*TW-1:TW];
    assign rd_hdl = rd_data_reg[ENT_W-1:2*TW];

    assign out_free  = !m_tvalid_reg || m_tready;
    assign walk_end  = !pend_reg && (i_reg >= cnt_reg);
    assign create_go = (in_timeout != '0) && (cnt_reg < SLOTS_C);
    assign delete_go = chk_active;

    sdtq_alloc #(
        .TIMER_SLOTS (TIMER_SLOTS)
    ) u_alloc (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (actl),
        .upd_handle  (upd_handle),
        .chk_handle  (in_handle),
        .chk_active  (chk_active),
        .stat        (astat),
        .free_handle (free_handle)
    );

    // list memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (s_tuser)
                        MODE_CREATE: state_next = create_go ? S_FIND : S_RESP;
                        MODE_DELETE: state_next = delete_go ? S_WALK : S_RESP;
                        MODE_TICK:   state_next = (cnt_reg != '0) ? S_HEAD : S_RESP;
                        default:     state_next = S_RESP;
                    endcase
                end
            end
            S_FIND:
            begin
                if (astat.found)
                begin
                    state_next = S_WALK;
                end
                else if (astat.exhausted)
                begin
                    state_next = S_RESP;
                end
            end
            S_HEAD:
            begin
                state_next = (rd_dl <= tick_reg) ? S_WALK : S_RESP;
            end
            S_WALK:
            begin
                if (walk_end)
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath, memory and allocator control
    always_comb
    begin
        tick_next     = tick_reg;
        cnt_next      = cnt_reg;
        i_next        = i_reg;
        pend_next     = pend_reg;
        p_idx_next    = p_idx_reg;
        flag_next     = flag_reg;
        del_next      = del_reg;
        carry_next    = carry_reg;
        ent_next      = ent_reg;
        tgt_next      = tgt_reg;
        status_next   = status_reg;
        nh_next       = nh_reg;
        fired_next    = fired_reg;
        fh_next       = fh_reg;
        ftag_next     = ftag_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        mem_we        = 1'b0;
        mem_waddr     = '0;
        mem_wdata     = '0;
        mem_re        = 1'b0;
        mem_raddr     = '0;
        actl          = '0;
        upd_handle    = tgt_reg;

        case (state_reg)
            // take a command and settle the quick cases
            S_IDLE:
            begin
                if (accept)
                begin
                    status_next = STAT_OK;
                    nh_next     = '0;
                    fired_next  = 1'b0;
                    fh_next     = '0;
                    ftag_next   = '0;
                    i_next      = '0;
                    pend_next   = 1'b0;
                    flag_next   = 1'b0;
                    case (s_tuser)
                        MODE_CREATE:
                        begin
                            del_next = 1'b0;
                            if (in_timeout == '0)
                            begin
                                status_next = STAT_ZERO;
                            end
                            else if (cnt_reg >= SLOTS_C)
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                ent_next        = {{HW{1'b0}}, in_tag, tick_reg + in_timeout};
                                actl.scan_start = 1'b1;
                            end
                        end
                        MODE_DELETE:
                        begin
                            del_next = 1'b1;
                            tgt_next = in_handle;
                            if (!delete_go)
                            begin
                                status_next = STAT_INACTIVE;
                            end
                        end
                        MODE_TICK:
                        begin
                            tick_next = tick_reg + 1'b1;
                            if (cnt_reg != '0)
                            begin
                                mem_re    = 1'b1;
                                mem_raddr = '0;
                            end
                        end
                        default:
                        begin
                            status_next = STAT_OK;
                        end
                    endcase
                end
            end
            // lowest free handle, one per cycle
            S_FIND:
            begin
                actl.scan_step = 1'b1;
                if (astat.found)
                begin
                    ent_next[ENT_W-1:2*TW] = free_handle;
                end
                else if (astat.exhausted)
                begin
                    status_next = STAT_FULL;
                end
            end
            // head check after a tick; a firing head enters the delete walk
            S_HEAD:
            begin
                if (rd_dl <= tick_reg)
                begin
                    fired_next = 1'b1;
                    fh_next    = rd_hdl;
                    ftag_next  = rd_tag;
                    tgt_next   = rd_hdl;
                    del_next   = 1'b1;
                    flag_next  = 1'b1;
                    i_next     = CW'(1);
                    pend_next  = 1'b0;
                end
            end
            // walk the list: read entry i, write back the shifted entry
            S_WALK:
            begin
                if (pend_reg)
                begin
                    if (del_reg)
                    begin
                        if (flag_reg)
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = p_idx_reg - 1'b1;
                            mem_wdata = rd_data_reg;
                        end
                        else if (rd_hdl == tgt_reg)
                        begin
                            flag_next = 1'b1;
                        end
                    end
                    else
                    begin
                        if (!flag_reg)
                        begin
                            if (rd_dl > ent_reg[TW-1:0])
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = p_idx_reg;
                                mem_wdata  = ent_reg;
                                carry_next = rd_data_reg;
                                flag_next  = 1'b1;
                            end
                        end
                        else
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = p_idx_reg;
                            mem_wdata  = carry_reg;
                            carry_next = rd_data_reg;
                        end
                    end
                end

                if (i_reg < cnt_reg)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = i_reg[HW-1:0];
                    pend_next  = 1'b1;
                    p_idx_next = i_reg[HW-1:0];
                    i_next     = i_reg + 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end

                // last step: tail write on create, and bookkeeping
                if (walk_end)
                begin
                    if (del_reg)
                    begin
                        actl.clr_en = 1'b1;
                        upd_handle  = tgt_reg;
                        if (flag_reg)
                        begin
                            cnt_next = cnt_reg - 1'b1;
                        end
                    end
                    else
                    begin
                        mem_we      = 1'b1;
                        mem_waddr   = cnt_reg[HW-1:0];
                        mem_wdata   = flag_reg ? carry_reg : ent_reg;
                        cnt_next    = cnt_reg + 1'b1;
                        actl.set_en = 1'b1;
                        upd_handle  = ent_reg[ENT_W-1:2*TW];
                        nh_next     = ent_reg[ENT_W-1:2*TW];
                    end
                end
            end
            // hand the result to the output register
            S_RESP:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{(OUT_W - OUT_F){1'b0}}, ftag_reg, fh_reg,
                                     fired_reg, nh_reg, status_reg};
                end
            end
            default:
            begin
                status_next = status_reg;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            tick_reg     <= '0;
            cnt_reg      <= '0;
            i_reg        <= '0;
            pend_reg     <= 1'b0;
            flag_reg     <= 1'b0;
            del_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            tick_reg     <= tick_next;
            cnt_reg      <= cnt_next;
            i_reg        <= i_next;
            pend_reg     <= pend_next;
            flag_reg     <= flag_next;
            del_reg      <= del_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        p_idx_reg   <= p_idx_next;
        carry_reg   <= carry_next;
        ent_reg     <= ent_next;
        tgt_reg     <= tgt_next;
        status_reg  <= status_next;
        nh_reg      <= nh_next;
        fired_reg   <= fired_next;
        fh_reg      <= fh_next;
        ftag_reg    <= ftag_next;
        m_tdata_reg <= m_tdata_next;
    end

    // entry count never passes the slot count
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= SLOTS_C)
        else $error("entry count above slot count");

    // a pending read during the walk always targets a valid entry
    a_walk_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK && pend_reg) |-> (CW'(p_idx_reg) < cnt_reg))
        else $error("walk read beyond valid entries");

    // an accepted command always leaves idle
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != S_IDLE))
        else $error("command accepted but sequencer stayed idle");

    // a result handed over shows up as a valid beat
    a_resp: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESP && out_free) |=> m_tvalid_reg)
        else $error("result lost on its way to the output register");

    // a full queue is never granted a new walk for create
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIND) |-> (cnt_reg < SLOTS_C))
        else $error("handle search started on a full queue");

endmodule

`default_nettype wire
